/* src/scst_pkg.sv */
`timescale 1ns / 1ps

package scst_pkg;

    localparam int FX_W        = 48;
    localparam int FRAC_W      = 40;
    localparam int ANGLE_W     = 31;
    localparam int ANGLE_SHIFT = 12;
    localparam int X_W         = ANGLE_W + ANGLE_SHIFT;
    localparam int X2_W        = 45;
    localparam int OUT_W       = 30;
    localparam int OUT_FRAC    = 28;
    localparam int SQ_W        = 29;
    localparam int ONE_OUT     = 268435456;
    localparam int COEF_N      = 24;

    typedef logic signed [FX_W-1:0] t_fx;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [X2_W-1:0]       x2;
        t_fx                   acc_s;
        t_fx                   acc_c;
    } t_lane;

    typedef enum logic [2:0] {
        KIND_SQUARE = 3'b001,
        KIND_HORNER = 3'b010,
        KIND_SINE   = 3'b100
    } t_kind;

    // (-1)^(k/2) / k!, rounded to nearest at 40 fractional bits
    localparam t_fx COEF [0:COEF_N-1] = '{
         48'sd1099511627776,
         48'sd1099511627776,
        -48'sd549755813888,
        -48'sd183251937963,
         48'sd45812984491,
         48'sd9162596898,
        -48'sd1527099483,
        -48'sd218157069,
         48'sd27269634,
         48'sd3029959,
        -48'sd302996,
        -48'sd27545,
         48'sd2295,
         48'sd177,
        -48'sd13,
        -48'sd1,
         48'sd0,
         48'sd0,
         48'sd0,
         48'sd0,
         48'sd0,
         48'sd0,
         48'sd0,
         48'sd0
    };

endpackage

/* src/sine_cosine_squares_taylor.sv */
`timescale 1ns / 1ps

// Sine and cosine of a Q2.28 angle by a TERM_COUNT-term Taylor series in Horner
// form over x^2, with 40 fractional bits inside. Results are rounded to Q1.28 and
// clamped to plus or minus one; squares are truncated to 28 fractional bits and
// summed. One request is taken every cycle unless back-pressure stalls the
// pipeline. The path runs through split 48-bit multiply stages (x squared,
// TERM_COUNT-1 Horner steps with sine and cosine lanes in parallel, final product
// with x), then round/clamp, square and sum stages. Each stage holds independently
// under back-pressure, so bubbles are squeezed out while a result waits.

module sine_cosine_squares_taylor
    import scst_pkg::*;
#(
    parameter int TERM_COUNT = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [OUT_W-1:0]   o_sine_value,
    output logic signed [OUT_W-1:0]   o_cosine_value,
    output logic [SQ_W-1:0]           o_sine_squared,
    output logic [SQ_W-1:0]           o_cosine_squared,
    output logic [OUT_W-1:0]          o_square_sum
);

    localparam int N_STEP = TERM_COUNT + 1;

    t_lane w_lane  [0:N_STEP];
    logic  w_valid [0:N_STEP];
    logic  w_ready [0:N_STEP];

    always_comb begin
        w_lane[0]       = '0;
        w_lane[0].x     = {i_angle, {ANGLE_SHIFT{1'b0}}};
    end

    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];

    generate
        for (genvar g = 0; g < N_STEP; g++) begin : g_step
            if (g == 0) begin : g_first
                scst_step #(
                    .KIND   (KIND_SQUARE),
                    .COEF_S (COEF[2*TERM_COUNT-1]),
                    .COEF_C (COEF[2*TERM_COUNT-2])
                ) u_step (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (w_valid[g]),
                    .o_ready (w_ready[g]),
                    .i_lane  (w_lane[g]),
                    .o_valid (w_valid[g+1]),
                    .i_ready (w_ready[g+1]),
                    .o_lane  (w_lane[g+1])
                );
            end else if (g == N_STEP - 1) begin : g_last
                scst_step #(
                    .KIND   (KIND_SINE),
                    .COEF_S ('0),
                    .COEF_C ('0)
                ) u_step (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (w_valid[g]),
                    .o_ready (w_ready[g]),
                    .i_lane  (w_lane[g]),
                    .o_valid (w_valid[g+1]),
                    .i_ready (w_ready[g+1]),
                    .o_lane  (w_lane[g+1])
                );
            end else begin : g_mid
                scst_step #(
                    .KIND   (KIND_HORNER),
                    .COEF_S (COEF[2*TERM_COUNT-1-2*g]),
                    .COEF_C (COEF[2*TERM_COUNT-2-2*g])
                ) u_step (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (w_valid[g]),
                    .o_ready (w_ready[g]),
                    .i_lane  (w_lane[g]),
                    .o_valid (w_valid[g+1]),
                    .i_ready (w_ready[g+1]),
                    .o_lane  (w_lane[g+1])
                );
            end
        end
    endgenerate

    scst_tail u_tail (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid[N_STEP]),
        .o_ready          (w_ready[N_STEP]),
        .i_sine           (w_lane[N_STEP].acc_s),
        .i_cosine         (w_lane[N_STEP].acc_c),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sine_value     (o_sine_value),
        .o_cosine_value   (o_cosine_value),
        .o_sine_squared   (o_sine_squared),
        .o_cosine_squared (o_cosine_squared),
        .o_square_sum     (o_square_sum)
    );

endmodule

/* src/scst_mul.sv */
`timescale 1ns / 1ps

module scst_mul
    import scst_pkg::*;
(
    input  logic i_clk,
    input  logic i_en1,
    input  logic i_en2,
    input  t_fx  i_a,
    input  t_fx  i_b,
    input  t_fx  i_c,
    output t_fx  o_r
);

    localparam int H   = FX_W / 2;
    localparam int P_W = 2 * FX_W;

    logic signed [H-1:0]   w_a_h;
    logic signed [H-1:0]   w_b_h;
    logic signed [H:0]     w_a_l;
    logic signed [H:0]     w_b_l;
    logic signed [2*H-1:0] n_hh;
    logic signed [2*H:0]   n_hl;
    logic signed [2*H:0]   n_lh;
    logic [2*H-1:0]        n_ll;
    logic signed [2*H-1:0] r_hh;
    logic signed [2*H:0]   r_hl;
    logic signed [2*H:0]   r_lh;
    logic [2*H-1:0]        r_ll;
    t_fx                   r_c;
    logic signed [P_W-1:0] w_sum;
    t_fx                   r_r;

    assign w_a_h = i_a[FX_W-1:H];
    assign w_b_h = i_b[FX_W-1:H];
    assign w_a_l = {1'b0, i_a[H-1:0]};
    assign w_b_l = {1'b0, i_b[H-1:0]};

    assign n_hh = w_a_h * w_b_h;
    assign n_hl = w_a_h * w_b_l;
    assign n_lh = w_a_l * w_b_h;
    assign n_ll = i_a[H-1:0] * i_b[H-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
            r_c  <= i_c;
        end
    end

    // addend enters at 2^40 so the floor shift stays exact
    assign w_sum = (P_W'(r_hh) <<< (2 * H))
                 + (P_W'(r_hl) <<< H)
                 + (P_W'(r_lh) <<< H)
                 + P_W'(r_ll)
                 + (P_W'(r_c) <<< FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_r <= w_sum[FRAC_W+FX_W-1:FRAC_W];
        end
    end

    assign o_r = r_r;

endmodule

/* src/scst_step.sv */
`timescale 1ns / 1ps

module scst_step
    import scst_pkg::*;
#(
    parameter t_kind KIND   = KIND_HORNER,
    parameter t_fx   COEF_S = '0,
    parameter t_fx   COEF_C = '0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_lane i_lane,
    output logic  o_valid,
    input  logic  i_ready,
    output t_lane o_lane
);

    logic  r_v1;
    logic  r_v2;
    logic  w_rdy1;
    logic  w_rdy2;
    t_lane r_p1;
    t_lane r_p2;
    t_fx   w_r_s;
    t_fx   w_r_c;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_p1 <= i_lane;
        end
        if (w_rdy2) begin
            r_p2 <= r_p1;
        end
    end

    generate
        if (KIND == KIND_SQUARE) begin : g_square
            scst_mul u_mul_s (
                .i_clk (i_clk),
                .i_en1 (w_rdy1),
                .i_en2 (w_rdy2),
                .i_a   (FX_W'(i_lane.x)),
                .i_b   (FX_W'(i_lane.x)),
                .i_c   ('0),
                .o_r   (w_r_s)
            );
            assign w_r_c = '0;
        end else if (KIND == KIND_SINE) begin : g_sine
            scst_mul u_mul_s (
                .i_clk (i_clk),
                .i_en1 (w_rdy1),
                .i_en2 (w_rdy2),
                .i_a   (i_lane.acc_s),
                .i_b   (FX_W'(i_lane.x)),
                .i_c   (COEF_S),
                .o_r   (w_r_s)
            );
            assign w_r_c = '0;
        end else begin : g_horner
            scst_mul u_mul_s (
                .i_clk (i_clk),
                .i_en1 (w_rdy1),
                .i_en2 (w_rdy2),
                .i_a   (i_lane.acc_s),
                .i_b   (FX_W'(i_lane.x2)),
                .i_c   (COEF_S),
                .o_r   (w_r_s)
            );
            scst_mul u_mul_c (
                .i_clk (i_clk),
                .i_en1 (w_rdy1),
                .i_en2 (w_rdy2),
                .i_a   (i_lane.acc_c),
                .i_b   (FX_W'(i_lane.x2)),
                .i_c   (COEF_C),
                .o_r   (w_r_c)
            );
        end
    endgenerate

    always_comb begin
        o_lane = r_p2;
        unique case (KIND)
            KIND_SQUARE: begin
                o_lane.x2    = w_r_s[X2_W-1:0];
                o_lane.acc_s = COEF_S;
                o_lane.acc_c = COEF_C;
            end
            KIND_SINE: begin
                o_lane.acc_s = w_r_s;
            end
            default: begin
                o_lane.acc_s = w_r_s;
                o_lane.acc_c = w_r_c;
            end
        endcase
    end

endmodule

/* src/scst_tail.sv */
`timescale 1ns / 1ps

module scst_tail
    import scst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_fx                     i_sine,
    input  t_fx                     i_cosine,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_sine_value,
    output logic signed [OUT_W-1:0] o_cosine_value,
    output logic [SQ_W-1:0]         o_sine_squared,
    output logic [SQ_W-1:0]         o_cosine_squared,
    output logic [OUT_W-1:0]        o_square_sum
);

    localparam int                    RND_SH = FRAC_W - OUT_FRAC;
    localparam int                    Q_W    = FX_W + 1 - RND_SH;
    localparam logic signed [OUT_W-1:0] ONE_V = OUT_W'(ONE_OUT);

    function automatic logic signed [OUT_W-1:0] round_clamp(input t_fx v);
        logic signed [FX_W:0]  t;
        logic signed [Q_W-1:0] q;
        logic signed [OUT_W-1:0] r;
        t = {v[FX_W-1], v} + (FX_W + 1)'(1 << (RND_SH - 1));
        q = t[FX_W:RND_SH];
        if (q > Q_W'(ONE_OUT)) begin
            r = ONE_V;
        end else if (q < -Q_W'(ONE_OUT)) begin
            r = -ONE_V;
        end else begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      w_rdy1;
    logic                      w_rdy2;
    logic                      w_rdy3;
    logic signed [OUT_W-1:0]   r_s1;
    logic signed [OUT_W-1:0]   r_c1;
    logic signed [OUT_W-1:0]   r_s2;
    logic signed [OUT_W-1:0]   r_c2;
    logic signed [2*OUT_W-1:0] n_s_prod;
    logic signed [2*OUT_W-1:0] n_c_prod;
    logic [SQ_W-1:0]           r_ss2;
    logic [SQ_W-1:0]           r_cs2;
    logic signed [OUT_W-1:0]   r_s3;
    logic signed [OUT_W-1:0]   r_c3;
    logic [SQ_W-1:0]           r_ss3;
    logic [SQ_W-1:0]           r_cs3;
    logic [OUT_W-1:0]          r_sum3;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign n_s_prod = r_s1 * r_s1;
    assign n_c_prod = r_c1 * r_c1;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1 <= round_clamp(i_sine);
            r_c1 <= round_clamp(i_cosine);
        end
        if (w_rdy2) begin
            r_s2  <= r_s1;
            r_c2  <= r_c1;
            r_ss2 <= n_s_prod[SQ_W+OUT_FRAC-1:OUT_FRAC];
            r_cs2 <= n_c_prod[SQ_W+OUT_FRAC-1:OUT_FRAC];
        end
        if (w_rdy3) begin
            r_s3   <= r_s2;
            r_c3   <= r_c2;
            r_ss3  <= r_ss2;
            r_cs3  <= r_cs2;
            r_sum3 <= OUT_W'(r_ss2) + OUT_W'(r_cs2);
        end
    end

    assign o_valid          = r_v3;
    assign o_sine_value     = r_s3;
    assign o_cosine_value   = r_c3;
    assign o_sine_squared   = r_ss3;
    assign o_cosine_squared = r_cs3;
    assign o_square_sum     = r_sum3;

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine_value <= ONE_V) && (o_sine_value >= -ONE_V)
                 && (o_cosine_value <= ONE_V) && (o_cosine_value >= -ONE_V))
        else $error("sine or cosine outside unit range");

    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_square_sum == OUT_W'(o_sine_squared) + OUT_W'(o_cosine_squared))
        else $error("square sum does not match squares");

    a_square_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine_squared <= SQ_W'(ONE_OUT)) && (o_cosine_squared <= SQ_W'(ONE_OUT)))
        else $error("square above one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_rdy2) |=> r_v2 && $stable(r_ss2) && $stable(r_cs2))
        else $error("stalled square stage lost its request");

endmodule

/* tb/sine_cosine_squares_taylor_tb.sv */
`timescale 1ns / 1ps

module sine_cosine_squares_taylor_tb;
    import scst_pkg::*;

    localparam int TERMS        = 10;
    localparam int LATENCY      = 2 * (TERMS + 1) + 3;
    localparam int RANDOM_ITEMS = 650;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PI_Q         = 843314857;
    localparam int HALF_PI_Q    = 421657428;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] sine;
        logic signed [OUT_W-1:0] cosine;
        logic [SQ_W-1:0]         sine_sq;
        logic [SQ_W-1:0]         cosine_sq;
        logic [OUT_W-1:0]        sq_sum;
    } trig_result_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_e;

    class trig_scoreboard;
        longint       coef [2*TERMS];
        trig_result_t expected_q [$];
        int           mismatches;
        int           angles_noted;
        int           results_checked;

        function new();
            longint unsigned one;
            longint unsigned f;
            longint          mag;
            bit              tiny;
            one  = 64'd1 << 40;
            f    = 1;
            tiny = 1'b0;
            mismatches      = 0;
            angles_noted    = 0;
            results_checked = 0;
            for (int k = 0; k < 2 * TERMS; k++) begin
                if (k > 1 && !tiny) begin
                    f = f * longint'(k);
                    if (f > (64'd1 << 41))
                        tiny = 1'b1;
                end
                mag = tiny ? 0 : longint'((one + f / 2) / f);
                coef[k] = ((k / 2) % 2 == 1) ? -mag : mag;
            end
        endfunction

        // floor(a*b / 2^40)
        function longint fx_mul(longint a, longint b);
            logic signed [127:0] wa;
            logic signed [127:0] wb;
            logic signed [127:0] p;
            wa = a;
            wb = b;
            p  = wa * wb;
            return longint'(p >>> 40);
        endfunction

        function longint round_clamp(longint v);
            longint r;
            r = (v + 2048) >>> 12;
            if (r > ONE_OUT)
                r = ONE_OUT;
            if (r < -ONE_OUT)
                r = -ONE_OUT;
            return r;
        endfunction

        function trig_result_t predict_trig(angle_t angle);
            longint       x;
            longint       x2;
            longint       acc;
            longint       s;
            longint       co;
            longint       ss;
            longint       cs;
            longint       sum;
            trig_result_t r;
            x  = longint'(angle) <<< ANGLE_SHIFT;
            x2 = fx_mul(x, x);
            acc = coef[2*TERMS-1];
            for (int k = 2 * TERMS - 3; k >= 1; k -= 2)
                acc = coef[k] + fx_mul(acc, x2);
            s = round_clamp(fx_mul(acc, x));
            acc = coef[2*TERMS-2];
            for (int k = 2 * TERMS - 4; k >= 0; k -= 2)
                acc = coef[k] + fx_mul(acc, x2);
            co  = round_clamp(acc);
            ss  = (s * s) >>> 28;
            cs  = (co * co) >>> 28;
            sum = ss + cs;
            r.sine      = s[OUT_W-1:0];
            r.cosine    = co[OUT_W-1:0];
            r.sine_sq   = ss[SQ_W-1:0];
            r.cosine_sq = cs[SQ_W-1:0];
            r.sq_sum    = sum[OUT_W-1:0];
            return r;
        endfunction

        function void note_angle(angle_t angle);
            expected_q.push_back(predict_trig(angle));
            angles_noted++;
        endfunction

        function void check_result(trig_result_t got);
            trig_result_t exp_r;
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result, nothing outstanding", $time);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] result %0d mismatch", $time, results_checked);
                    $display("  sin    exp %0d got %0d", exp_r.sine, got.sine);
                    $display("  cos    exp %0d got %0d", exp_r.cosine, got.cosine);
                    $display("  sin^2  exp %0d got %0d", exp_r.sine_sq, got.sine_sq);
                    $display("  cos^2  exp %0d got %0d", exp_r.cosine_sq, got.cosine_sq);
                    $display("  sum    exp %0d got %0d", exp_r.sq_sum, got.sq_sum);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    angle_t                  i_angle;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_sine_value;
    logic signed [OUT_W-1:0] o_cosine_value;
    logic [SQ_W-1:0]         o_sine_squared;
    logic [SQ_W-1:0]         o_cosine_squared;
    logic [OUT_W-1:0]        o_square_sum;

    trig_scoreboard sb;
    int             cycle_count = 0;
    bit             long_hold_done;

    angle_t directed_angles [20] = '{
        31'sd0, 31'sd1, -31'sd1, 31'sd1073741823, -31'sd1073741824,
        31'sd268435456, -31'sd268435456, 31'sd536870912, -31'sd536870912,
        31'sd210828714, 31'sd421657428, -31'sd421657428, 31'sd421657427,
        31'sd421657429, 31'sd843314857, -31'sd843314857, 31'sd4096, -31'sd4096,
        31'h2AAAAAAA, 31'h55555555
    };

    sine_cosine_squares_taylor #(
        .TERM_COUNT(TERMS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_angle          (i_angle),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sine_value     (o_sine_value),
        .o_cosine_value   (o_cosine_value),
        .o_sine_squared   (o_sine_squared),
        .o_cosine_squared (o_cosine_squared),
        .o_square_sum     (o_square_sum)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial sb = new();

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_angle(i_angle);
            if (o_valid && i_ready)
                sb.check_result('{o_sine_value, o_cosine_value, o_sine_squared,
                                  o_cosine_squared, o_square_sum});
        end
    end

    function automatic angle_t rand_angle();
        int v;
        case ($urandom_range(0, 9))
            6, 7:    v = int'($urandom_range(0, 2 * PI_Q)) - PI_Q;
            8:       v = int'($urandom_range(0, 131071)) - 65536;
            9: begin
                v = HALF_PI_Q + int'($urandom_range(0, 4000)) - 2000;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = int'($urandom);
        endcase
        return angle_t'(v);
    endfunction

    task automatic send_angle(input angle_t a);
        i_valid <= 1'b1;
        i_angle <= a;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // receiver: random stall segments, one long hold once traffic is flowing
    initial begin
        rx_mode_e mode;
        int       seg;
        bit       rdy;
        long_hold_done = 1'b0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!long_hold_done && sb.results_checked >= 150) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = rx_mode_e'($urandom_range(0, 3));
                seg  = $urandom_range(16, 80);
                repeat (seg) begin
                    case (mode)
                        RX_FREE:   rdy = 1'b1;
                        RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
                        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                        default:   rdy = ($urandom_range(0, 7) != 0);
                    endcase
                    i_ready <= rdy;
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int sent;
        int burst;
        int gap;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_angle <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_angles[i])
            send_angle(directed_angles[i]);
        wait_all_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 48);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                send_angle(rand_angle());
                sent++;
            end
            if (sent == RANDOM_ITEMS) begin
                // done
            end else if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
                wait_all_results();
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0)
                    pause_sender(gap);
            end
        end

        wait_all_results();
        repeat (LATENCY + 15) @(posedge i_clk);

        $display("Checked %0d sine/cosine results against %0d angle requests, %0d mismatches.",
                 sb.results_checked, sb.angles_noted, sb.mismatches);
        $display("Directed extremes and quadrant points, random full-range angles, %0d-cycle output hold.",
                 LONG_HOLD);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
